// File: rtl/trz_pkg.sv
// ----------------------------------------------------------------------------
// trz_pkg
// Shared types and constants of the triangle z-buffer rasterizer: transaction
// codes, field widths, the queued item layout and the state machine types.
// ----------------------------------------------------------------------------
package trz_pkg;

   // transaction codes
   typedef enum logic [1:0] {
      MODE_CLEAR = 2'd0,
      MODE_DRAW  = 2'd1,
      MODE_READ  = 2'd2,
      MODE_NOP   = 2'd3
   } mode_type;

   localparam int COORD_W  = 16;
   localparam int DEPTH_W  = 24;
   localparam int COLOUR_W = 32;
   localparam int INDEX_W  = 14;
   localparam int COUNT_W  = 15;
   localparam int AREA_W   = 35;
   localparam int INV_W    = 24;

   // depth of the queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // one classified transaction as it waits for the back end
   typedef struct packed {
      mode_type                  mode;
      logic [2:0][COORD_W-1:0]   vx;
      logic [2:0][COORD_W-1:0]   vy;
      logic [2:0][DEPTH_W-1:0]   vd;
      logic [COLOUR_W-1:0]       colour;
      logic [INDEX_W-1:0]        read_index;
      logic [AREA_W-1:0]         area;
      logic                      reject;
   } item_type;

   typedef enum logic [1:0] {
      F_IDLE,
      F_MUL,
      F_PUSH
   } front_state_type;

   typedef enum logic [3:0] {
      B_IDLE,
      B_CLEAR,
      B_READ,
      B_INV,
      B_INV_WAIT,
      B_SETUP,
      B_PIX,
      B_MUL,
      B_DIV_START,
      B_DIV_WAIT,
      B_CMP,
      B_RESP
   } back_state_type;

endpackage

// File: rtl/trz_front.sv
// ----------------------------------------------------------------------------
// trz_front
// Accepts transactions, works out the signed triangle area and the reject
// flag, and pushes the classified transaction into the queue.
// ----------------------------------------------------------------------------
module trz_front import trz_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 hold,
   output logic                 busy,
   input  logic [1:0]           req_mode,
   input  logic [COORD_W-1:0]   req_v0_x,
   input  logic [COORD_W-1:0]   req_v0_y,
   input  logic [DEPTH_W-1:0]   req_v0_depth,
   input  logic [COORD_W-1:0]   req_v1_x,
   input  logic [COORD_W-1:0]   req_v1_y,
   input  logic [DEPTH_W-1:0]   req_v1_depth,
   input  logic [COORD_W-1:0]   req_v2_x,
   input  logic [COORD_W-1:0]   req_v2_y,
   input  logic [DEPTH_W-1:0]   req_v2_depth,
   input  logic [COLOUR_W-1:0]  req_fill_colour,
   input  logic [INDEX_W-1:0]   req_read_index,
   input  logic                 q_full,
   output logic                 q_push,
   output item_type             q_item
);

   front_state_type           state_ff, state_in;
   item_type                  item_ff;
   logic signed [33:0]        p1_ff, p2_ff;
   logic                      accept;
   logic signed [16:0]        dx1, dy1, dx2, dy2;
   logic signed [AREA_W-1:0]  area;
   logic                      depth_bad;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         F_IDLE: begin
            if (accept) state_in = F_MUL;
         end
         F_MUL: begin
            state_in = F_PUSH;
         end
         F_PUSH: begin
            if (!q_full) state_in = F_IDLE;
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   // handshake outputs
   always_comb begin
      busy   = (state_ff != F_IDLE) || hold;
      accept = start && !busy;
      q_push = (state_ff == F_PUSH) && !q_full;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // capture the transaction
   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff.mode       <= mode_type'(req_mode);
         item_ff.vx         <= {req_v2_x, req_v1_x, req_v0_x};
         item_ff.vy         <= {req_v2_y, req_v1_y, req_v0_y};
         item_ff.vd         <= {req_v2_depth, req_v1_depth, req_v0_depth};
         item_ff.colour     <= req_fill_colour;
         item_ff.read_index <= req_read_index;
         item_ff.area       <= '0;
         item_ff.reject     <= 1'b0;
      end
   end

   // edge vectors from vertex 0
   always_comb begin
      dx1 = 17'($signed(item_ff.vx[1])) - 17'($signed(item_ff.vx[0]));
      dy1 = 17'($signed(item_ff.vy[1])) - 17'($signed(item_ff.vy[0]));
      dx2 = 17'($signed(item_ff.vx[2])) - 17'($signed(item_ff.vx[0]));
      dy2 = 17'($signed(item_ff.vy[2])) - 17'($signed(item_ff.vy[0]));
   end

   // cross products, registered
   always_ff @(posedge clock) begin
      if (state_ff == F_MUL) begin
         p1_ff <= dx1 * dy2;
         p2_ff <= dy1 * dx2;
      end
   end

   // area and reject
   always_comb begin
      area      = AREA_W'(p1_ff) - AREA_W'(p2_ff);
      depth_bad = ($signed(item_ff.vd[0]) <= 0) || ($signed(item_ff.vd[1]) <= 0) ||
                  ($signed(item_ff.vd[2]) <= 0);
      q_item        = item_ff;
      q_item.area   = area;
      q_item.reject = depth_bad || (area == '0);
   end

endmodule

// File: rtl/trz_fifo.sv
// ----------------------------------------------------------------------------
// trz_fifo
// Short queue of classified transactions between front and back end.
// ----------------------------------------------------------------------------
module trz_fifo import trz_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  item_type  push_item,
   input  logic      pop,
   output logic      full,
   output logic      empty,
   output item_type  head
);

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   item_type        slot_ff [QUEUE_DEPTH];
   logic [PW-1:0]   wr_ff, rd_ff;
   logic [PW:0]     cnt_ff;

   always_comb begin
      full  = (cnt_ff == (PW+1)'(QUEUE_DEPTH));
      empty = (cnt_ff == '0);
      head  = slot_ff[rd_ff];
   end

   // store entries
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_item;
      end
   end

   // advance pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= (wr_ff == PW'(QUEUE_DEPTH-1)) ? '0 : wr_ff + 1'b1;
         if (pop)  rd_ff <= (rd_ff == PW'(QUEUE_DEPTH-1)) ? '0 : rd_ff + 1'b1;
         cnt_ff <= cnt_ff + (PW+1)'(push) - (PW+1)'(pop);
      end
   end

endmodule

// File: rtl/trz_div.sv
// ----------------------------------------------------------------------------
// trz_div
// Restoring divider, one quotient bit per cycle. The numerator must be below
// the denominator shifted up by the quotient width.
// ----------------------------------------------------------------------------
module trz_div import trz_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              div_start,
   input  logic [59:0]       div_num,
   input  logic [35:0]       div_den,
   output logic [INV_W-1:0]  div_q,
   output logic              div_done
);

   logic [35:0]       rem_ff, den_ff;
   logic [INV_W-1:0]  low_ff, q_ff;
   logic [4:0]        cnt_ff;
   logic              run_ff, done_ff;
   logic [36:0]       trial;
   logic              ge;

   // one subtract and compare
   always_comb begin
      trial    = {rem_ff, low_ff[INV_W-1]};
      ge       = trial >= {1'b0, den_ff};
      div_q    = q_ff;
      div_done = done_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= run_ff && (cnt_ff == 5'(INV_W-1));
         if (div_start) begin
            run_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (run_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == 5'(INV_W-1)) run_ff <= 1'b0;
         end
      end
   end

   // shift one numerator bit in per cycle
   always_ff @(posedge clock) begin
      if (div_start) begin
         rem_ff <= div_num[59:INV_W];
         low_ff <= div_num[INV_W-1:0];
         den_ff <= div_den;
         q_ff   <= '0;
      end else if (run_ff) begin
         rem_ff <= ge ? 36'(trial - {1'b0, den_ff}) : trial[35:0];
         low_ff <= {low_ff[INV_W-2:0], 1'b0};
         q_ff   <= {q_ff[INV_W-2:0], ge};
      end
   end

endmodule

// File: rtl/trz_back.sv
// ----------------------------------------------------------------------------
// trz_back
// Carries out queued transactions: clears both stores, reads a colour, or
// walks a triangle's clamped bounding box one pixel at a time with
// incremental edge functions, interpolates inverse depth and depth-tests.
// ----------------------------------------------------------------------------
module trz_back import trz_pkg::*; #(
   parameter int SCREEN_WIDTH  = 128,
   parameter int SCREEN_HEIGHT = 128
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_empty,
   input  item_type             q_head,
   output logic                 q_pop,
   output logic                 init_busy,
   output logic                 rsp_valid,
   output logic [COLOUR_W-1:0]  rsp_pixel_colour,
   output logic [COUNT_W-1:0]   rsp_pixels_written,
   output logic                 rsp_rejected
);

   localparam int NPIX = SCREEN_WIDTH * SCREEN_HEIGHT;
   localparam int AW   = $clog2(NPIX);
   localparam int XW   = $clog2(SCREEN_WIDTH);
   localparam int YW   = $clog2(SCREEN_HEIGHT);
   localparam int EW   = 36;
   localparam logic signed [13:0] XMAX = 14'(SCREEN_WIDTH - 1);
   localparam logic signed [13:0] YMAX = 14'(SCREEN_HEIGHT - 1);

   function automatic logic [1:0] vert_a(input logic [1:0] j);
      logic [1:0] r;
      case (j)
         2'd0:    r = 2'd1;
         2'd1:    r = 2'd2;
         default: r = 2'd0;
      endcase
      return r;
   endfunction

   function automatic logic [1:0] vert_b(input logic [1:0] j);
      logic [1:0] r;
      case (j)
         2'd0:    r = 2'd2;
         2'd1:    r = 2'd0;
         default: r = 2'd1;
      endcase
      return r;
   endfunction

   // stores
   logic [COLOUR_W-1:0]  colour_mem [NPIX];
   logic [INV_W-1:0]     idepth_mem [NPIX];

   back_state_type             state_ff, state_in;
   item_type                   cur_ff;
   logic                       init_ff;
   logic [AW-1:0]              addr_ff, row_addr_ff;
   logic [XW-1:0]              px_ff, x0_ff, x1_ff;
   logic [YW-1:0]              py_ff, y1_ff;
   logic signed [16:0]         dx_ff [3];
   logic signed [16:0]         dy_ff [3];
   logic signed [EW-1:0]       ef_ff [3];
   logic signed [EW-1:0]       efrow_ff [3];
   logic [INV_W-1:0]           inv_ff [3];
   logic [1:0]                 vi_ff;
   logic [2:0]                 mstep_ff;
   logic signed [42:0]         prod_ff;
   logic [59:0]                num_ff;
   logic [33:0]                aarea_ff;
   logic                       pos_ff;
   logic                       in_range_ff;
   logic [COUNT_W-1:0]         written_ff;
   logic [COLOUR_W-1:0]        colour_rd_ff;
   logic [INV_W-1:0]           idepth_rd_ff;
   logic                       rsp_valid_ff;
   logic [COLOUR_W-1:0]        rsp_colour_ff;
   logic [COUNT_W-1:0]         rsp_written_ff;
   logic                       rsp_rejected_ff;

   // head box
   logic signed [15:0]         hx [3];
   logic signed [15:0]         hy [3];
   logic signed [15:0]         minx, maxx, miny, maxy;
   logic signed [16:0]         cx_up, cy_up;
   logic signed [13:0]         bx0, bx1, by0, by1;
   logic                       box_empty;
   logic [AW-1:0]              start_addr, read_addr;
   logic                       head_in_range;
   logic signed [AREA_W-1:0]   harea;
   logic [AREA_W-1:0]          habs;

   // control
   logic                       d_is_one, covered, last_col, last_row, advance, nearer;
   logic                       mem_we;
   logic [COLOUR_W-1:0]        wr_colour;
   logic [INV_W-1:0]           wr_idepth;
   logic                       div_start, div_done;
   logic [59:0]                div_num;
   logic [35:0]                div_den;
   logic [INV_W-1:0]           div_q;
   logic [1:0]                 mj, kj;
   logic                       mt, kt;
   logic [2:0]                 kstep;
   logic signed [17:0]         op_a;
   logic signed [24:0]         op_b;
   logic signed [17:0]         cx0, cy0, ax_s, ay_s;
   logic [EW-1:0]              emag;

   // bounding box of the queued triangle, floor of minimum, ceiling of maximum
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         hx[i] = $signed(q_head.vx[i]);
         hy[i] = $signed(q_head.vy[i]);
      end
      minx = (hx[0] < hx[1]) ? hx[0] : hx[1];
      minx = (minx < hx[2]) ? minx : hx[2];
      maxx = (hx[0] > hx[1]) ? hx[0] : hx[1];
      maxx = (maxx > hx[2]) ? maxx : hx[2];
      miny = (hy[0] < hy[1]) ? hy[0] : hy[1];
      miny = (miny < hy[2]) ? miny : hy[2];
      maxy = (hy[0] > hy[1]) ? hy[0] : hy[1];
      maxy = (maxy > hy[2]) ? maxy : hy[2];
      cx_up = 17'(maxx) + 17'sd15;
      cy_up = 17'(maxy) + 17'sd15;
      bx0 = 14'(minx >>> 4);
      by0 = 14'(miny >>> 4);
      bx1 = 14'(cx_up >>> 4);
      by1 = 14'(cy_up >>> 4);
      if (bx0 < 14'sd0) bx0 = 14'sd0;
      if (by0 < 14'sd0) by0 = 14'sd0;
      if (bx1 > XMAX) bx1 = XMAX;
      if (by1 > YMAX) by1 = YMAX;
      box_empty  = (bx0 > bx1) || (by0 > by1);
      start_addr = AW'(32'(by0[YW-1:0]) * 32'(SCREEN_WIDTH) + 32'(bx0[XW-1:0]));
      read_addr  = AW'(32'(q_head.read_index));
      head_in_range = 32'(q_head.read_index) < 32'(NPIX);
      harea = $signed(q_head.area);
      habs  = harea[AREA_W-1] ? AREA_W'(-harea) : AREA_W'(harea);
   end

   // pixel tests
   always_comb begin
      d_is_one = (cur_ff.vd[vi_ff] == DEPTH_W'(1));
      covered  = pos_ff ? ((ef_ff[0] >= 0) && (ef_ff[1] >= 0) && (ef_ff[2] >= 0))
                        : ((ef_ff[0] <= 0) && (ef_ff[1] <= 0) && (ef_ff[2] <= 0));
      last_col = (px_ff == x1_ff);
      last_row = (py_ff == y1_ff);
      nearer   = div_q > idepth_rd_ff;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         B_IDLE: begin
            if (!q_empty) begin
               case (q_head.mode)
                  MODE_CLEAR: state_in = B_CLEAR;
                  MODE_READ:  state_in = B_READ;
                  MODE_DRAW:  state_in = (q_head.reject || box_empty) ? B_RESP : B_INV;
                  default:    state_in = B_RESP;
               endcase
            end
         end
         B_CLEAR: begin
            if (addr_ff == AW'(NPIX - 1)) state_in = init_ff ? B_IDLE : B_RESP;
         end
         B_READ: begin
            state_in = B_RESP;
         end
         B_INV: begin
            if (!d_is_one)          state_in = B_INV_WAIT;
            else if (vi_ff == 2'd2) state_in = B_SETUP;
         end
         B_INV_WAIT: begin
            if (div_done) state_in = (vi_ff == 2'd2) ? B_SETUP : B_INV;
         end
         B_SETUP: begin
            if (mstep_ff == 3'd6) state_in = B_PIX;
         end
         B_PIX: begin
            if (covered)                  state_in = B_MUL;
            else if (last_col && last_row) state_in = B_RESP;
         end
         B_MUL: begin
            if (mstep_ff == 3'd6) state_in = B_DIV_START;
         end
         B_DIV_START: begin
            state_in = B_DIV_WAIT;
         end
         B_DIV_WAIT: begin
            if (div_done) state_in = B_CMP;
         end
         B_CMP: begin
            state_in = (last_col && last_row) ? B_RESP : B_PIX;
         end
         B_RESP: begin
            state_in = B_IDLE;
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   // control outputs
   always_comb begin
      q_pop     = (state_ff == B_IDLE) && !q_empty;
      advance   = ((state_ff == B_PIX) && !covered) || (state_ff == B_CMP);
      mem_we    = (state_ff == B_CLEAR) || ((state_ff == B_CMP) && nearer);
      wr_colour = (state_ff == B_CMP) ? cur_ff.colour : '0;
      wr_idepth = (state_ff == B_CMP) ? div_q : '0;
      div_start = ((state_ff == B_INV) && !d_is_one) || (state_ff == B_DIV_START);
      div_num   = (state_ff == B_INV) ? 60'(1) << INV_W : num_ff;
      div_den   = (state_ff == B_INV) ? 36'(cur_ff.vd[vi_ff]) : 36'(aarea_ff);
      init_busy = init_ff;
   end

   // multiplier operands: edge setup terms or magnitude halves times inverse depth
   always_comb begin
      mj   = (mstep_ff[2:1] == 2'd3) ? 2'd0 : mstep_ff[2:1];
      mt   = mstep_ff[0];
      ax_s = 18'($signed(cur_ff.vx[vert_a(mj)]));
      ay_s = 18'($signed(cur_ff.vy[vert_a(mj)]));
      cx0  = $signed(18'({px_ff, 4'b1000}));
      cy0  = $signed(18'({py_ff, 4'b1000}));
      emag = ef_ff[mj][EW-1] ? EW'(-ef_ff[mj]) : EW'(ef_ff[mj]);
      if (state_ff == B_SETUP) begin
         op_a = mt ? 18'(dy_ff[mj]) : 18'(dx_ff[mj]);
         op_b = mt ? 25'(cx0 - ax_s) : 25'(cy0 - ay_s);
      end else begin
         op_a = $signed({1'b0, mt ? emag[33:17] : emag[16:0]});
         op_b = $signed({1'b0, inv_ff[mj]});
      end
      kstep = mstep_ff - 3'd1;
      kj    = kstep[2:1];
      kt    = kstep[0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_CLEAR;
         init_ff      <= 1'b1;
         addr_ff      <= '0;
         mstep_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= (state_ff == B_RESP);
         if ((state_ff == B_CLEAR) && (addr_ff == AW'(NPIX - 1))) init_ff <= 1'b0;
         mstep_ff <= ((state_ff == B_SETUP) || (state_ff == B_MUL)) ? mstep_ff + 3'd1 : 3'd0;
         // hold the single store address
         if (q_pop) begin
            case (q_head.mode)
               MODE_READ: addr_ff <= read_addr;
               MODE_DRAW: addr_ff <= start_addr;
               default:   addr_ff <= '0;
            endcase
         end else if (state_ff == B_CLEAR) begin
            addr_ff <= addr_ff + 1'b1;
         end else if (advance) begin
            addr_ff <= last_col ? row_addr_ff + AW'(SCREEN_WIDTH) : addr_ff + 1'b1;
         end
      end
   end

   // transaction set-up on pop
   always_ff @(posedge clock) begin
      if (q_pop) begin
         cur_ff      <= q_head;
         in_range_ff <= head_in_range;
         written_ff  <= '0;
         vi_ff       <= '0;
         px_ff       <= bx0[XW-1:0];
         x0_ff       <= bx0[XW-1:0];
         x1_ff       <= bx1[XW-1:0];
         py_ff       <= by0[YW-1:0];
         y1_ff       <= by1[YW-1:0];
         row_addr_ff <= start_addr;
         aarea_ff    <= habs[33:0];
         pos_ff      <= !harea[AREA_W-1];
         for (int j = 0; j < 3; j++) begin
            dx_ff[j] <= 17'($signed(q_head.vx[vert_b(2'(j))])) -
                        17'($signed(q_head.vx[vert_a(2'(j))]));
            dy_ff[j] <= 17'($signed(q_head.vy[vert_b(2'(j))])) -
                        17'($signed(q_head.vy[vert_a(2'(j))]));
         end
      end else begin
         // per-vertex inverse depth
         if ((state_ff == B_INV) && d_is_one) begin
            inv_ff[vi_ff] <= {INV_W{1'b1}};
            vi_ff         <= vi_ff + 1'b1;
         end else if ((state_ff == B_INV_WAIT) && div_done) begin
            inv_ff[vi_ff] <= div_q;
            vi_ff         <= vi_ff + 1'b1;
         end
         // write counter, saturating
         if ((state_ff == B_CMP) && nearer && (written_ff != {COUNT_W{1'b1}})) begin
            written_ff <= written_ff + 1'b1;
         end
         // step to the next pixel
         if (advance) begin
            if (last_col) begin
               px_ff       <= x0_ff;
               py_ff       <= py_ff + 1'b1;
               row_addr_ff <= row_addr_ff + AW'(SCREEN_WIDTH);
               for (int j = 0; j < 3; j++) begin
                  efrow_ff[j] <= efrow_ff[j] + (EW'(dx_ff[j]) <<< 4);
                  ef_ff[j]    <= efrow_ff[j] + (EW'(dx_ff[j]) <<< 4);
               end
            end else begin
               px_ff <= px_ff + 1'b1;
               for (int j = 0; j < 3; j++) begin
                  ef_ff[j] <= ef_ff[j] - (EW'(dy_ff[j]) <<< 4);
               end
            end
         end
         // accumulate edge values at the box corner
         if ((state_ff == B_SETUP) && (mstep_ff != 3'd0)) begin
            if (!kt) begin
               ef_ff[kj]    <= EW'(prod_ff);
               efrow_ff[kj] <= EW'(prod_ff);
            end else begin
               ef_ff[kj]    <= ef_ff[kj] - EW'(prod_ff);
               efrow_ff[kj] <= efrow_ff[kj] - EW'(prod_ff);
            end
         end
      end
   end

   // multiplier and weighted-sum accumulator
   always_ff @(posedge clock) begin
      prod_ff <= op_a * op_b;
      if (state_ff == B_PIX) begin
         num_ff <= '0;
      end else if ((state_ff == B_MUL) && (mstep_ff != 3'd0)) begin
         num_ff <= num_ff + (60'(prod_ff) << (kt ? 17 : 0));
      end
   end

   // stores: one write, registered reads at the same address
   always_ff @(posedge clock) begin
      if (mem_we) begin
         colour_mem[addr_ff] <= wr_colour;
         idepth_mem[addr_ff] <= wr_idepth;
      end
      colour_rd_ff <= colour_mem[addr_ff];
      idepth_rd_ff <= idepth_mem[addr_ff];
   end

   // result register
   always_ff @(posedge clock) begin
      if (state_ff == B_RESP) begin
         rsp_colour_ff   <= ((cur_ff.mode == MODE_READ) && in_range_ff) ? colour_rd_ff : '0;
         rsp_written_ff  <= (cur_ff.mode == MODE_DRAW) ? written_ff : '0;
         rsp_rejected_ff <= (cur_ff.mode == MODE_DRAW) && cur_ff.reject;
      end
   end

   always_comb begin
      rsp_valid          = rsp_valid_ff;
      rsp_pixel_colour   = rsp_colour_ff;
      rsp_pixels_written = rsp_written_ff;
      rsp_rejected       = rsp_rejected_ff;
   end

   trz_div u_div (
      .clock     (clock),
      .reset     (reset),
      .div_start (div_start),
      .div_num   (div_num),
      .div_den   (div_den),
      .div_q     (div_q),
      .div_done  (div_done)
   );

endmodule

// File: rtl/triangle_zbuffer_rasterizer.sv
// ----------------------------------------------------------------------------
// triangle_zbuffer_rasterizer
// Triangle rasterizer with colour and inverse-depth stores.
// ----------------------------------------------------------------------------
// Read: front end, queue, B_READ, B_RESP. Clear: one store entry per cycle.
// Rejected or empty draw: straight to B_RESP. Draw: an inverse-depth division
// per vertex whose depth is not 1 and the edge set-up, then each uncovered box
// pixel is stepped past and each covered one takes 6 multiplies and a 24-step
// divide. One transaction runs at a time, up to three wait; the receiver cannot
// stall. After reset busy stays high while both stores are cleared.
module triangle_zbuffer_rasterizer import trz_pkg::*; #(
   parameter int SCREEN_WIDTH  = 128,
   parameter int SCREEN_HEIGHT = 128
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [1:0]           req_mode,
   input  logic [COORD_W-1:0]   req_v0_x,
   input  logic [COORD_W-1:0]   req_v0_y,
   input  logic [DEPTH_W-1:0]   req_v0_depth,
   input  logic [COORD_W-1:0]   req_v1_x,
   input  logic [COORD_W-1:0]   req_v1_y,
   input  logic [DEPTH_W-1:0]   req_v1_depth,
   input  logic [COORD_W-1:0]   req_v2_x,
   input  logic [COORD_W-1:0]   req_v2_y,
   input  logic [DEPTH_W-1:0]   req_v2_depth,
   input  logic [COLOUR_W-1:0]  req_fill_colour,
   input  logic [INDEX_W-1:0]   req_read_index,
   output logic                 rsp_valid,
   output logic [COLOUR_W-1:0]  rsp_pixel_colour,
   output logic [COUNT_W-1:0]   rsp_pixels_written,
   output logic                 rsp_rejected
);

   item_type  push_item, head;
   logic      push, pop, full, empty, init_busy;

   trz_front u_front (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .hold            (init_busy),
      .busy            (busy),
      .req_mode        (req_mode),
      .req_v0_x        (req_v0_x),
      .req_v0_y        (req_v0_y),
      .req_v0_depth    (req_v0_depth),
      .req_v1_x        (req_v1_x),
      .req_v1_y        (req_v1_y),
      .req_v1_depth    (req_v1_depth),
      .req_v2_x        (req_v2_x),
      .req_v2_y        (req_v2_y),
      .req_v2_depth    (req_v2_depth),
      .req_fill_colour (req_fill_colour),
      .req_read_index  (req_read_index),
      .q_full          (full),
      .q_push          (push),
      .q_item          (push_item)
   );

   trz_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .full      (full),
      .empty     (empty),
      .head      (head)
   );

   trz_back #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .q_empty            (empty),
      .q_head             (head),
      .q_pop              (pop),
      .init_busy          (init_busy),
      .rsp_valid          (rsp_valid),
      .rsp_pixel_colour   (rsp_pixel_colour),
      .rsp_pixels_written (rsp_pixels_written),
      .rsp_rejected       (rsp_rejected)
   );

endmodule

// File: rtl/trz_checker.sv
// ----------------------------------------------------------------------------
// trz_checker
// Port-level checks of the rasterizer, bound to the top level.
// ----------------------------------------------------------------------------
module trz_checker import trz_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 start,
   input logic                 busy,
   input logic                 rsp_valid,
   input logic [COLOUR_W-1:0]  rsp_pixel_colour,
   input logic [COUNT_W-1:0]   rsp_pixels_written,
   input logic                 rsp_rejected
);

   // results are single-cycle strobes, never back to back
   a_strobe_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result strobe held two cycles");

   // a dropped triangle writes nothing and reads nothing
   a_reject_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_rejected) |-> (rsp_pixels_written == '0 && rsp_pixel_colour == '0))
      else $error("rejected result carries data");

   // a draw result that wrote pixels carries no colour and is not rejected
   a_draw_no_colour: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_pixels_written != '0) |-> (rsp_pixel_colour == '0 && !rsp_rejected))
      else $error("draw result carries colour");

   // store clearing holds off transactions after reset
   a_init_busy: assert property (@(posedge clock)
      $fell(reset) |-> busy) else $error("not busy after reset");

   // an accepted transaction blocks the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("busy did not rise after accept");

endmodule

bind triangle_zbuffer_rasterizer trz_checker u_trz_checker (.*);

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the triangle z-buffer rasterizer. It drives clear,
// draw, read and no-operation transactions and predicts every response with
// its own copy of the colour and inverse-depth stores. It then compares each
// response field by field, in order.
// ----------------------------------------------------------------------------
module testbench;
   import trz_pkg::*;

   localparam int W    = 128;
   localparam int H    = 128;
   localparam int NPIX = W * H;
   localparam longint unsigned INV_SAT = 64'hFFFFFF;

   typedef struct packed {
      mode_type            mode;
      logic [15:0]         v0_x, v0_y;
      logic [23:0]         v0_depth;
      logic [15:0]         v1_x, v1_y;
      logic [23:0]         v1_depth;
      logic [15:0]         v2_x, v2_y;
      logic [23:0]         v2_depth;
      logic [31:0]         colour;
      logic [13:0]         read_index;
   } raster_txn_type;

   typedef struct packed {
      logic [31:0] colour;
      logic [14:0] written;
      logic        rejected;
   } raster_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_mode = '0;
   logic [15:0] req_v0_x = '0, req_v0_y = '0, req_v1_x = '0, req_v1_y = '0;
   logic [15:0] req_v2_x = '0, req_v2_y = '0;
   logic [23:0] req_v0_depth = '0, req_v1_depth = '0, req_v2_depth = '0;
   logic [31:0] req_fill_colour = '0;
   logic [13:0] req_read_index = '0;
   logic        rsp_valid;
   logic [31:0] rsp_pixel_colour;
   logic [14:0] rsp_pixels_written;
   logic        rsp_rejected;

   logic [31:0] colour_mem [0:NPIX-1];
   logic [23:0] invz_mem   [0:NPIX-1];
   raster_rsp_type expected_rsps[$];
   int          mismatches = 0;
   int          gap_pct    = 0;

   always #6 clock = ~clock;

   triangle_zbuffer_rasterizer #(.SCREEN_WIDTH(W), .SCREEN_HEIGHT(H)) i_dut (
      .clock, .reset, .start, .busy,
      .req_mode, .req_v0_x, .req_v0_y, .req_v0_depth,
      .req_v1_x, .req_v1_y, .req_v1_depth,
      .req_v2_x, .req_v2_y, .req_v2_depth,
      .req_fill_colour, .req_read_index,
      .rsp_valid, .rsp_pixel_colour, .rsp_pixels_written, .rsp_rejected
   );

   function automatic longint edge_val(longint ax, longint ay, longint bx, longint by,
                                       longint px, longint py);
      return (bx - ax) * (py - ay) - (by - ay) * (px - ax);
   endfunction

   function automatic longint unsigned magnitude(longint v);
      return (v < 0) ? longint'(-v) : v;
   endfunction

   // Advance the store copy by one transaction and return its response
   function automatic raster_rsp_type rasterize(raster_txn_type t);
      raster_rsp_type  r;
      longint          x[3], y[3], d[3], e[3];
      longint          area, bx0, bx1, by0, by1, cx, cy;
      longint unsigned inv[3], aarea, num, id, q;
      int              idx;
      bit              covered;
      r = '0;
      case (t.mode)
         MODE_CLEAR: begin
            for (int i = 0; i < NPIX; i++) begin
               colour_mem[i] = '0;
               invz_mem[i]   = '0;
            end
         end
         MODE_READ: r.colour = colour_mem[t.read_index];
         MODE_DRAW: begin
            x[0] = longint'($signed(t.v0_x)); y[0] = longint'($signed(t.v0_y));
            x[1] = longint'($signed(t.v1_x)); y[1] = longint'($signed(t.v1_y));
            x[2] = longint'($signed(t.v2_x)); y[2] = longint'($signed(t.v2_y));
            d[0] = longint'($signed(t.v0_depth));
            d[1] = longint'($signed(t.v1_depth));
            d[2] = longint'($signed(t.v2_depth));
            area = edge_val(x[0], y[0], x[1], y[1], x[2], y[2]);
            if (d[0] <= 0 || d[1] <= 0 || d[2] <= 0 || area == 0) begin
               r.rejected = 1'b1;
            end else begin
               aarea = magnitude(area);
               for (int k = 0; k < 3; k++) begin
                  q = (64'd1 << 24) / longint'(d[k]);
                  inv[k] = (q > INV_SAT) ? INV_SAT : q;
               end
               // floor of the minimum, ceiling of the maximum, then clamp
               bx0 = (x[0] < x[1] ? (x[0] < x[2] ? x[0] : x[2]) : (x[1] < x[2] ? x[1] : x[2]));
               bx1 = (x[0] > x[1] ? (x[0] > x[2] ? x[0] : x[2]) : (x[1] > x[2] ? x[1] : x[2]));
               by0 = (y[0] < y[1] ? (y[0] < y[2] ? y[0] : y[2]) : (y[1] < y[2] ? y[1] : y[2]));
               by1 = (y[0] > y[1] ? (y[0] > y[2] ? y[0] : y[2]) : (y[1] > y[2] ? y[1] : y[2]));
               bx0 = bx0 >>> 4;  by0 = by0 >>> 4;
               bx1 = (bx1 + 15) >>> 4;  by1 = (by1 + 15) >>> 4;
               if (bx0 < 0) bx0 = 0;
               if (by0 < 0) by0 = 0;
               if (bx1 > W - 1) bx1 = W - 1;
               if (by1 > H - 1) by1 = H - 1;
               for (longint py = by0; py <= by1; py++) begin
                  for (longint px = bx0; px <= bx1; px++) begin
                     cx = px * 16 + 8;
                     cy = py * 16 + 8;
                     e[0] = edge_val(x[1], y[1], x[2], y[2], cx, cy);
                     e[1] = edge_val(x[2], y[2], x[0], y[0], cx, cy);
                     e[2] = edge_val(x[0], y[0], x[1], y[1], cx, cy);
                     covered = (area > 0) ? (e[0] >= 0 && e[1] >= 0 && e[2] >= 0)
                                          : (e[0] <= 0 && e[1] <= 0 && e[2] <= 0);
                     if (covered) begin
                        num = magnitude(e[0]) * inv[0] + magnitude(e[1]) * inv[1]
                            + magnitude(e[2]) * inv[2];
                        id = num / aarea;
                        if (id > INV_SAT) id = INV_SAT;
                        idx = int'(py) * W + int'(px);
                        if (id > longint'(invz_mem[idx])) begin
                           invz_mem[idx]   = id[23:0];
                           colour_mem[idx] = t.colour;
                           if (r.written < 15'h7FFF) r.written++;
                        end
                     end
                  end
               end
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   // Drive one transaction, hold it until accepted, then record the prediction
   task automatic send_txn(raster_txn_type t);
      start           <= 1'b1;
      req_mode        <= t.mode;
      req_v0_x        <= t.v0_x;  req_v0_y <= t.v0_y;  req_v0_depth <= t.v0_depth;
      req_v1_x        <= t.v1_x;  req_v1_y <= t.v1_y;  req_v1_depth <= t.v1_depth;
      req_v2_x        <= t.v2_x;  req_v2_y <= t.v2_y;  req_v2_depth <= t.v2_depth;
      req_fill_colour <= t.colour;
      req_read_index  <= t.read_index;
      @(posedge clock);
      while (busy) @(posedge clock);
      expected_rsps.push_back(rasterize(t));
      // idle the request side now and then
      if ($urandom_range(99) < gap_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   function automatic raster_txn_type make_draw(int x0, int y0, int x1, int y1, int x2, int y2,
                                                int d0, int d1, int d2, logic [31:0] c);
      raster_txn_type t;
      t = '0;
      t.mode = MODE_DRAW;
      t.v0_x = x0[15:0]; t.v0_y = y0[15:0]; t.v0_depth = d0[23:0];
      t.v1_x = x1[15:0]; t.v1_y = y1[15:0]; t.v1_depth = d1[23:0];
      t.v2_x = x2[15:0]; t.v2_y = y2[15:0]; t.v2_depth = d2[23:0];
      t.colour = c;
      return t;
   endfunction

   function automatic raster_txn_type make_simple(mode_type m, int unsigned idx);
      raster_txn_type t;
      t = '0;
      t.mode = m;
      t.read_index = idx[13:0];
      return t;
   endfunction

   // Small triangle near a random pixel, mostly in the top-left corner
   function automatic raster_txn_type random_small_draw();
      raster_txn_type t;
      int bx, by, dmax;
      bx = ($urandom_range(9) == 0) ? $urandom_range(131) - 3 : $urandom_range(22) - 3;
      by = ($urandom_range(9) == 0) ? $urandom_range(131) - 3 : $urandom_range(22) - 3;
      dmax = ($urandom_range(3) == 0) ? 8388607 : 4096;
      t = make_draw(bx * 16 + $urandom_range(90) - 8, by * 16 + $urandom_range(90) - 8,
                    bx * 16 + $urandom_range(90) - 8, by * 16 + $urandom_range(90) - 8,
                    bx * 16 + $urandom_range(90) - 8, by * 16 + $urandom_range(90) - 8,
                    $urandom_range(dmax, 1), $urandom_range(dmax, 1),
                    $urandom_range(dmax, 1), $urandom());
      return t;
   endfunction

   task automatic test_directed();
      send_txn(make_simple(MODE_NOP, 0));
      send_txn(make_simple(MODE_READ, 0));
      send_txn(make_simple(MODE_READ, NPIX - 1));
      // negative, zero depth and zero area are dropped
      send_txn(make_draw(0, 0, 160, 0, 0, 160, -8388608, 256, 256, 32'hFFFFFFFF));
      send_txn(make_draw(0, 0, 160, 0, 0, 160, 256, 0, 256, 32'h1));
      send_txn(make_draw(0, 0, 80, 80, 160, 160, 256, 256, 256, 32'h2));
      // both windings, overlapping, nearer then farther then nearer
      send_txn(make_draw(8, 8, 200, 8, 8, 200, 512, 512, 512, 32'hA5A5A5A5));
      send_txn(make_draw(8, 8, 8, 200, 200, 8, 1024, 1024, 1024, 32'h5A5A5A5A));
      send_txn(make_draw(8, 8, 8, 200, 200, 8, 1, 1, 8388607, 32'h0F0F0F0F));
      send_txn(make_simple(MODE_READ, 0));
      send_txn(make_simple(MODE_READ, W + 1));
      // box wholly off screen, then one clipped at the far corner
      send_txn(make_draw(32767, 32767, 32000, 32767, 32767, 32000, 256, 256, 256, 32'h3));
      send_txn(make_draw(2000, 2000, 2100, 2040, 2040, 2100, 256, 300, 400, 32'h4));
      send_txn(make_simple(MODE_READ, NPIX - 1));
      // one huge triangle whose box spans the whole screen but covers no pixel centre
      send_txn(make_draw(-32768, -32768, 32767, -32768, -32768, 32767,
                         8388607, 8388607, 8388607, 32'h12345678));
      send_txn(make_simple(MODE_READ, 5000));
      send_txn(make_simple(MODE_CLEAR, 0));
      send_txn(make_simple(MODE_READ, 5000));
   endtask

   task automatic test_random(int n_items, int idle_pct);
      raster_txn_type t;
      int             sel;
      gap_pct = idle_pct;
      for (int i = 0; i < n_items; i++) begin
         sel = $urandom_range(999);
         if (sel < 2) begin
            t = make_simple(MODE_CLEAR, $urandom());
         end else if (sel < 30) begin
            t = make_simple(MODE_NOP, $urandom());
         end else if (sel < 100) begin
            // full-range noise, forced to fail on depth
            t = make_draw($urandom(), $urandom(), $urandom(), $urandom(),
                          $urandom(), $urandom(), $urandom(), $urandom(),
                          $urandom(), $urandom());
            t.v1_depth[23] = 1'b1;
         end else if (sel < 520) begin
            t = random_small_draw();
         end else begin
            t = ($urandom_range(3) == 0) ? make_simple(MODE_READ, $urandom())
                : make_simple(MODE_READ, $urandom_range(24) * W + $urandom_range(24));
         end
         t.mode = mode_type'(t.mode);
         send_txn(t);
      end
   endtask

   // Compare each response with the oldest prediction
   always @(posedge clock) begin
      raster_rsp_type exp_rsp;
      if (!reset && rsp_valid) begin
         if (expected_rsps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response colour=%h written=%0d rejected=%b",
                        rsp_pixel_colour, rsp_pixels_written, rsp_rejected);
         end else begin
            exp_rsp = expected_rsps.pop_front();
            if (rsp_pixel_colour !== exp_rsp.colour || rsp_pixels_written !== exp_rsp.written
                || rsp_rejected !== exp_rsp.rejected) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected colour=%h written=%0d rejected=%b, got %h %0d %b",
                           exp_rsp.colour, exp_rsp.written, exp_rsp.rejected,
                           rsp_pixel_colour, rsp_pixels_written, rsp_rejected);
            end
         end
      end
   end

   initial begin
      for (int i = 0; i < NPIX; i++) begin
         colour_mem[i] = '0;
         invz_mem[i]   = '0;
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      gap_pct = 10;
      test_directed();
      test_random(530, 22);
      test_random(530, 58);
      test_random(540, 0);
      start <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (mismatches == 0 && expected_rsps.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   // Hard stop for a hung block
   initial begin
      #(12 * 8000000);
      $display("Regression FAIL");
      $finish;
   end

endmodule
